@@ src/jwl_pkg.sv @@
// ----------------------------------------------------------------------------
// JWL pressure package
// Shared types, register codes, fixed-point constants and pipeline latencies.
// ----------------------------------------------------------------------------
package jwl_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TAYLOR_TERMS  = 12;
  localparam int DIV_BITS      = 43;

  localparam int EXP_LAT   = 5 + 3 * TAYLOR_TERMS + 2;
  localparam int THERM_LAT = 4 + DIV_BITS + 1;
  localparam int OUT_LAT   = THERM_LAT + 1;

  localparam logic [32:0] LOG2E   = 33'h1_7154_7653;
  localparam logic [31:0] LN2     = 32'hB172_17F8;
  localparam logic [38:0] X_CAP   = 39'h40_0000_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [42:0] MAG_CAP = 43'h400_0000_0000;
  localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_COEF_A     = 3'd0,
    REG_COEF_B     = 3'd1,
    REG_RATE_R1    = 3'd2,
    REG_RATE_R2    = 3'd3,
    REG_OMEGA      = 3'd4,
    REG_HEAT_CAP   = 3'd5,
    REG_REF_TEMP   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [23:0] rate_r1;
    logic [23:0] rate_r2;
    logic [17:0] gruneisen_omega;
    logic [31:0] heat_capacity;
    logic [23:0] reference_temperature;
  } cfg_t;

  typedef struct packed {
    logic [23:0] temperature;
    logic [19:0] relative_volume;
  } request_t;

  typedef struct packed {
    logic [31:0] pressure;
    logic        clamped_to_zero;
    logic        saturated;
  } result_t;

  typedef struct packed {
    logic [34:0] mag;
    logic        neg;
    logic        vol_zero;
  } therm_t;

endpackage

@@ src/jwl_pressure_eos.sv @@
// ----------------------------------------------------------------------------
// JWL pressure equation of state
// Temperature-dependent Jones-Wilkins-Lee pressure in unsigned fixed point.
// ----------------------------------------------------------------------------
// Once out of reset, the block takes one request in every cycle and returns
// its result in request order, with done high for one cycle; the receiver
// cannot stall. The latency is set by the thermal path, whose 43-stage
// divider produces one quotient bit per stage, while the two exponential
// units (twelve series steps of three stages each) are delayed to line up
// with it. Configuration is written through its own port, which is always
// ready, and must not change while requests are in flight.
module jwl_pressure_eos #(
  parameter int FRAC_BITS = jwl_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  jwl_pkg::request_t  request,
  output logic               done,
  output jwl_pkg::result_t   result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DLY = jwl_pkg::THERM_LAT - jwl_pkg::EXP_LAT;

  jwl_pkg::cfg_t   cfg;
  jwl_pkg::therm_t th;
  logic            accept;
  logic            va, vb, th_valid;
  logic [31:0]     pa, pb;
  logic [DLY-1:0]  dv;
  logic [31:0]     p1d [DLY];
  logic [31:0]     p2d [DLY];
  logic [36:0]     base;
  logic [36:0]     sum;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jwl_pkg::cfg_reg_t'(cfg_index))
        jwl_pkg::REG_COEF_A:   cfg.coef_a <= cfg_data;
        jwl_pkg::REG_COEF_B:   cfg.coef_b <= cfg_data;
        jwl_pkg::REG_RATE_R1:  cfg.rate_r1 <= cfg_data[23:0];
        jwl_pkg::REG_RATE_R2:  cfg.rate_r2 <= cfg_data[23:0];
        jwl_pkg::REG_OMEGA:    cfg.gruneisen_omega <= cfg_data[17:0];
        jwl_pkg::REG_HEAT_CAP: cfg.heat_capacity <= cfg_data;
        jwl_pkg::REG_REF_TEMP: cfg.reference_temperature <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  jwl_exp_term #(.FRAC_BITS(FRAC_BITS)) u_exp_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .rate      (cfg.rate_r1),
    .vol       (request.relative_volume),
    .coef      (cfg.coef_a),
    .out_valid (va),
    .term      (pa)
  );

  jwl_exp_term #(.FRAC_BITS(FRAC_BITS)) u_exp_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .rate      (cfg.rate_r2),
    .vol       (request.relative_volume),
    .coef      (cfg.coef_b),
    .out_valid (vb),
    .term      (pb)
  );

  jwl_thermal u_thermal (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .temperature (request.temperature),
    .vol         (request.relative_volume),
    .cfg         (cfg),
    .out_valid   (th_valid),
    .out         (th)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else begin
      dv <= {dv[DLY-2:0], va};
    end
  end

  always_ff @(posedge clk) begin
    p1d[0] <= pa;
    p2d[0] <= pb;
    for (int i = 1; i < DLY; i++) begin
      p1d[i] <= p1d[i-1];
      p2d[i] <= p2d[i-1];
    end
  end

  assign base = 37'(p1d[DLY-1]) + 37'(p2d[DLY-1]);
  assign sum  = th.neg ? (base - 37'(th.mag)) : (base + 37'(th.mag));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= th_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (th.vol_zero) begin
      result <= '{pressure: jwl_pkg::OUT_MAX, clamped_to_zero: 1'b0, saturated: 1'b1};
    end else if (sum[36]) begin
      result <= '{pressure: 32'd0, clamped_to_zero: 1'b1, saturated: 1'b0};
    end else if (|sum[35:32]) begin
      result <= '{pressure: jwl_pkg::OUT_MAX, clamped_to_zero: 1'b0, saturated: 1'b1};
    end else begin
      result <= '{pressure: sum[31:0], clamped_to_zero: 1'b0, saturated: 1'b0};
    end
  end

  a_branch_align: assert property (@(posedge clk) disable iff (rst)
    (dv[DLY-1] == th_valid) && (va == vb))
    else $error("exponential and thermal paths out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(jwl_pkg::OUT_LAT) done)
    else $error("request did not produce a result at the expected cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.clamped_to_zero && result.saturated))
    else $error("clamp and saturation flags both set");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.clamped_to_zero) |-> (result.pressure == 32'd0))
    else $error("clamped result has nonzero pressure");

endmodule

@@ src/jwl_exp_term.sv @@
// ----------------------------------------------------------------------------
// JWL exponential term
// Pipelined coef * exp(-rate * V) with a twelve-term series for the fraction.
// ----------------------------------------------------------------------------
module jwl_exp_term #(
  parameter int FRAC_BITS = jwl_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [23:0] rate,
  input  logic [19:0] vol,
  input  logic [31:0] coef,
  output logic        out_valid,
  output logic [31:0] term
);

  localparam int XSH   = 2 * FRAC_BITS - 16;
  localparam int STEPS = jwl_pkg::TAYLOR_TERMS;

  logic        v1, v2, v3, v4, ve;
  logic [43:0] prod;
  logic [38:0] x;
  logic [55:0] ph;
  logic [48:0] pl;
  logic [7:0]  n4;
  logic [31:0] f4;
  logic [32:0] e;

  logic [59:0] xw;
  logic [55:0] ysum;
  logic [63:0] zprod;
  logic [64:0] ce;
  logic [7:0]  n_last;

  logic [STEPS:0] sv;
  logic [32:0]    ss [STEPS+1];
  logic [31:0]    sz [STEPS+1];
  logic [7:0]     sn [STEPS+1];

  assign xw    = {prod, 16'b0} >> XSH;
  assign ysum  = ph + 56'(pl[48:16]);
  assign zprod = 64'(f4) * 64'(jwl_pkg::LN2);
  assign ce    = 65'(coef) * 65'(e);
  assign n_last = sn[STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      sv[0] <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      sv[0] <= v4;
      ve <= sv[STEPS];
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 44'(rate) * 44'(vol);
    x <= (xw > 60'(jwl_pkg::X_CAP)) ? jwl_pkg::X_CAP : xw[38:0];
    ph <= 56'(x[38:16]) * 56'(jwl_pkg::LOG2E);
    pl <= 49'(x[15:0]) * 49'(jwl_pkg::LOG2E);
    n4 <= ysum[55:48];
    f4 <= ysum[47:16];
    sz[0] <= zprod[63:32];
    ss[0] <= jwl_pkg::ONE_Q32;
    sn[0] <= n4;
    e <= (n_last >= 8'd33) ? 33'd0 : (ss[STEPS] >> n_last[5:0]);
    term <= ce[63:32];
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam int          K     = STEPS - i;
    localparam logic [36:0] RECIP = 37'((64'd1 << 36) / K);

    logic        va, vb;
    logic [31:0] ta, tb, qb, za, zb;
    logic [7:0]  na, nb;
    logic [64:0] zs;
    logic [68:0] tr;
    logic [31:0] rem;
    logic [31:0] q;

    assign zs  = 65'(sz[i]) * 65'(ss[i]);
    assign tr  = 69'(ta) * 69'(RECIP);
    assign rem = tb - 32'(qb * 32'(K));
    assign q   = qb + 32'(rem >= 32'(K));

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
        vb <= 1'b0;
        sv[i+1] <= 1'b0;
      end else begin
        va <= sv[i];
        vb <= va;
        sv[i+1] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      ta <= zs[63:32];
      za <= sz[i];
      na <= sn[i];
      tb <= ta;
      qb <= tr[67:36];
      zb <= za;
      nb <= na;
      ss[i+1] <= jwl_pkg::ONE_Q32 - 33'(q);
      sz[i+1] <= zb;
      sn[i+1] <= nb;
    end
  end

endmodule

@@ src/jwl_thermal.sv @@
// ----------------------------------------------------------------------------
// JWL thermal term
// Pipelined omega * Cv * |T - Tref| / V with a bit-per-stage divider.
// ----------------------------------------------------------------------------
module jwl_thermal (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [23:0]       temperature,
  input  logic [19:0]       vol,
  input  jwl_pkg::cfg_t     cfg,
  output logic              out_valid,
  output jwl_pkg::therm_t   out
);

  localparam int NB = jwl_pkg::DIV_BITS;

  logic        v1, v2, v3;
  logic [49:0] m;
  logic [23:0] dt;
  logic        neg1, neg2, neg3;
  logic [19:0] vol1, vol2, vol3;
  logic        vz1, vz2, vz3;
  logic [48:0] pph, ppl;
  logic [73:0] prod;
  logic        neg_in;

  logic [NB:0] dv;
  logic [19:0] dr   [NB+1];
  logic [42:0] dq   [NB+1];
  logic [42:0] dl   [NB+1];
  logic [19:0] dvol [NB+1];
  logic        dneg [NB+1];
  logic        dvz  [NB+1];
  logic        dovf [NB+1];

  logic [42:0] mag_full;

  assign neg_in   = temperature < cfg.reference_temperature;
  assign mag_full = (dovf[NB] || (dq[NB] > jwl_pkg::MAG_CAP)) ? jwl_pkg::MAG_CAP : dq[NB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      dv[0] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      dv[0] <= v3;
      out_valid <= dv[NB];
    end
  end

  always_ff @(posedge clk) begin
    m <= 50'(cfg.gruneisen_omega) * 50'(cfg.heat_capacity);
    dt <= neg_in ? (cfg.reference_temperature - temperature)
                 : (temperature - cfg.reference_temperature);
    neg1 <= neg_in;
    vol1 <= vol;
    vz1 <= (vol == 20'd0);
    pph <= 49'(m[49:25]) * 49'(dt);
    ppl <= 49'(m[24:0]) * 49'(dt);
    neg2 <= neg1;
    vol2 <= vol1;
    vz2 <= vz1;
    prod <= {pph, 25'b0} + 74'(ppl);
    neg3 <= neg2;
    vol3 <= vol2;
    vz3 <= vz2;
    dovf[0] <= prod[73:43] >= 31'(vol3);
    dr[0] <= prod[62:43];
    dl[0] <= prod[42:0];
    dq[0] <= '0;
    dvol[0] <= vol3;
    dneg[0] <= neg3;
    dvz[0] <= vz3;
    out.mag <= mag_full[42:8];
    out.neg <= dneg[NB];
    out.vol_zero <= dvz[NB];
  end

  for (genvar j = 0; j < NB; j++) begin : g_div
    logic [20:0] r2;
    logic        ge;

    assign r2 = {dr[j], dl[j][NB-1-j]};
    assign ge = r2 >= {1'b0, dvol[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      dr[j+1] <= ge ? 20'(r2 - {1'b0, dvol[j]}) : r2[19:0];
      dq[j+1] <= {dq[j][41:0], ge};
      dl[j+1] <= dl[j];
      dvol[j+1] <= dvol[j];
      dneg[j+1] <= dneg[j];
      dvz[j+1] <= dvz[j];
      dovf[j+1] <= dovf[j];
    end
  end

endmodule

@@ dv/jwl_pressure_eos_tb.sv @@
// ----------------------------------------------------------------------------
// JWL pressure equation of state testbench
// Drives temperature and volume requests through the request port under
// several register settings, predicts each pressure result in fixed point and
// compares it, field by field and in order, with what the block returns.
// ----------------------------------------------------------------------------
module jwl_pressure_eos_tb;

  localparam int FB        = jwl_pkg::FRAC_BITS_DEF;
  localparam int TAIL      = jwl_pkg::OUT_LAT + 20;
  localparam int IDLE_MAX  = 4000;
  localparam int N_PHASES  = 10;
  localparam int PHASE_LEN = 110;

  class pressure_scoreboard;
    bit [63:0]         r_coef_a, r_coef_b, r_rate_r1, r_rate_r2;
    bit [63:0]         r_omega, r_heat_cap, r_ref_temp;
    jwl_pkg::result_t  pending[$];
    int                errors;

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (jwl_pkg::cfg_reg_t'(idx))
        jwl_pkg::REG_COEF_A:   r_coef_a   = 64'(data);
        jwl_pkg::REG_COEF_B:   r_coef_b   = 64'(data);
        jwl_pkg::REG_RATE_R1:  r_rate_r1  = 64'(data[23:0]);
        jwl_pkg::REG_RATE_R2:  r_rate_r2  = 64'(data[23:0]);
        jwl_pkg::REG_OMEGA:    r_omega    = 64'(data[17:0]);
        jwl_pkg::REG_HEAT_CAP: r_heat_cap = 64'(data);
        jwl_pkg::REG_REF_TEMP: r_ref_temp = 64'(data[23:0]);
        default: ;
      endcase
    endfunction

    function bit [63:0] exp_neg(bit [63:0] x);
      bit [63:0] y, n, f, z, s;
      if (x > 64'(jwl_pkg::X_CAP)) x = 64'(jwl_pkg::X_CAP);
      y = ((x >> 16) * 64'(jwl_pkg::LOG2E)
           + (((x & 64'hFFFF) * 64'(jwl_pkg::LOG2E)) >> 16)) >> 16;
      n = y >> 32;
      f = y & 64'hFFFF_FFFF;
      if (n >= 64'd33) return 64'd0;
      z = (f * 64'(jwl_pkg::LN2)) >> 32;
      s = 64'(jwl_pkg::ONE_Q32);
      for (int k = jwl_pkg::TAYLOR_TERMS; k >= 1; k--)
        s = 64'(jwl_pkg::ONE_Q32) - ((z * s) >> 32) / 64'(k);
      return s >> n;
    endfunction

    function bit [63:0] exp_term(bit [63:0] coef, bit [63:0] rate, bit [63:0] vol);
      bit [63:0] prod, x;
      prod = rate * vol;
      if (2 * FB >= 32) x = prod >> (2 * FB - 32);
      else x = prod << (32 - 2 * FB);
      return (coef * exp_neg(x)) >> 32;
    endfunction

    function jwl_pkg::result_t predict(jwl_pkg::request_t r);
      jwl_pkg::result_t res;
      bit [63:0]        temp, vol, p1, p2, m, q1, rm, dt, mag;
      bit               neg;
      longint           sum;
      temp = 64'(r.temperature);
      vol  = 64'(r.relative_volume);
      res  = '0;
      if (vol == 64'd0) begin
        res.pressure  = jwl_pkg::OUT_MAX;
        res.saturated = 1'b1;
        return res;
      end
      p1  = exp_term(r_coef_a, r_rate_r1, vol);
      p2  = exp_term(r_coef_b, r_rate_r2, vol);
      neg = temp < r_ref_temp;
      dt  = neg ? r_ref_temp - temp : temp - r_ref_temp;
      m   = r_omega * r_heat_cap;
      q1  = m / vol;
      rm  = m % vol;
      if (dt != 64'd0 && q1 > 64'(jwl_pkg::MAG_CAP) / dt) mag = 64'(jwl_pkg::MAG_CAP);
      else mag = q1 * dt + (rm * dt) / vol;
      if (mag > 64'(jwl_pkg::MAG_CAP)) mag = 64'(jwl_pkg::MAG_CAP);
      mag = mag >> 8;
      sum = longint'(p1) + longint'(p2);
      if (neg) sum = sum - longint'(mag);
      else sum = sum + longint'(mag);
      if (sum < 0) begin
        res.clamped_to_zero = 1'b1;
      end else if (sum > longint'(64'hFFFF_FFFF)) begin
        res.pressure  = jwl_pkg::OUT_MAX;
        res.saturated = 1'b1;
      end else begin
        res.pressure = sum[31:0];
      end
      return res;
    endfunction

    function void note_request(jwl_pkg::request_t r);
      pending.push_back(predict(r));
    endfunction

    function void check_result(jwl_pkg::result_t got);
      jwl_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pressure !== want.pressure) begin
        $display("%0t: pressure expected %h actual %h", $time, want.pressure, got.pressure);
        errors++;
      end
      if (got.clamped_to_zero !== want.clamped_to_zero) begin
        $display("%0t: clamped_to_zero expected %b actual %b", $time,
                 want.clamped_to_zero, got.clamped_to_zero);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time,
                 want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  jwl_pkg::request_t request = '0;
  logic              done;
  jwl_pkg::result_t  result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [31:0]       cfg_data = '0;

  pressure_scoreboard sb = new();
  int unsigned n_taken = 0;
  int unsigned n_cfg = 0;
  int unsigned idle_cycles = 0;

  jwl_pressure_eos u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(request);
        n_taken <= n_taken + 1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        n_cfg <= n_cfg + 1;
      end
      if (done) sb.check_result(result);
      if ((start && !busy) || (cfg_valid && cfg_ready) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("jwl_pressure_eos_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_request(logic [23:0] t, logic [19:0] v);
    int unsigned target;
    target = n_taken + 1;
    start   <= 1'b1;
    request <= '{temperature: t, relative_volume: v};
    wait (n_taken == target);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(jwl_pkg::cfg_reg_t idx, logic [31:0] data);
    int unsigned target;
    target = n_cfg + 1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    wait (n_cfg == target);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] a, logic [31:0] b, logic [23:0] r1,
                         logic [23:0] r2, logic [17:0] om, logic [31:0] cv,
                         logic [23:0] tr);
    write_reg(jwl_pkg::REG_COEF_A, a);
    write_reg(jwl_pkg::REG_COEF_B, b);
    write_reg(jwl_pkg::REG_RATE_R1, 32'(r1));
    write_reg(jwl_pkg::REG_RATE_R2, 32'(r2));
    write_reg(jwl_pkg::REG_OMEGA, 32'(om));
    write_reg(jwl_pkg::REG_HEAT_CAP, cv);
    write_reg(jwl_pkg::REG_REF_TEMP, 32'(tr));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [19:0] pick_volume();
    case ($urandom_range(0, 5))
      0: return 20'($urandom_range(0, 16));
      1: return 20'($urandom_range(32'h8000, 32'h20000));
      2: return 20'($urandom_range(32'h20000, 32'hFFFFF));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] a, b, cv;
    logic [23:0] r1, r2, tr;
    logic [17:0] om;
    a  = $urandom;
    b  = $urandom_range(0, 3) == 0 ? $urandom : $urandom >> $urandom_range(0, 24);
    r1 = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(0, 32'h80000));
    r2 = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(0, 32'h20000));
    om = 18'($urandom);
    cv = $urandom >> $urandom_range(0, 28);
    tr = 24'($urandom);
    set_all(a, b, r1, r2, om, cv, tr);
  endtask

  initial begin
    logic [23:0] t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset: every point is zero pressure except V of zero.
    send_request(24'h0, 20'h0);
    send_request(24'hFFFFFF, 20'h10000);
    pause_sender(3);
    drain();

    set_all(32'h0064_0000, 32'h0002_0000, 24'h04_8000, 24'h01_0000,
            18'h0_4CCD, 32'h0001_0000, 24'h012C00);
    send_request(24'h012C00, 20'h10000);
    send_request(24'h012C00, 20'h0);
    send_request(24'h000000, 20'h10000);
    send_request(24'hFFFFFF, 20'h10000);
    send_request(24'h000000, 20'h00001);
    send_request(24'hFFFFFF, 20'h00001);
    send_request(24'h012C00, 20'hFFFFF);
    send_request(24'h00FF00, 20'h08000);
    send_request(24'h000000, 20'h0);
    drain();

    set_all(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
            18'h3FFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    send_request(24'h000000, 20'h00001);
    send_request(24'hFFFFFF, 20'h00001);
    send_request(24'hFFFFFF, 20'hFFFFF);
    send_request(24'h000000, 20'hFFFFF);
    send_request(24'h000000, 20'h0);
    drain();

    set_all(32'hFFFFFFFF, 32'hFFFFFFFF, 24'h0, 24'h0, 18'h3FFFF, 32'hFFFFFFFF, 24'h0);
    send_request(24'hFFFFFF, 20'h00001);
    send_request(24'h000000, 20'h10000);
    send_request(24'h000100, 20'hFFFFF);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      random_config();
      for (int i = 0; i < PHASE_LEN; i++) begin
        case ($urandom_range(0, 3))
          0: t = 24'($urandom);
          1: t = sb.r_ref_temp[23:0] + 24'($urandom_range(0, 512)) - 24'd256;
          default: t = sb.r_ref_temp[23:0] ^ (24'd1 << $urandom_range(0, 23));
        endcase
        if ((p % 3) != 0 && $urandom_range(0, 7) == 0)
          pause_sender($urandom_range(1, 20));
        send_request(t, pick_volume());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("jwl_pressure_eos_tb: clean");
    end else begin
      $display("jwl_pressure_eos_tb: errors");
    end
    $finish;
  end
endmodule
